// ----- hdl/nsd_pkg.sv -----
// Shared types, constants and the transition table for the trigram digest.
package nsd_pkg;

    localparam int COUNT_W      = 27;
    localparam int ACC_N        = 256;
    localparam int IDX_W        = 8;
    localparam int TOTAL_OFFSET = 28;
    localparam int SHORT_LEN    = 4;
    localparam int HIST_N       = 4;

    typedef logic [7:0]         t_byte;
    typedef logic [IDX_W-1:0]   t_idx;
    typedef logic [COUNT_W-1:0] t_count;

    typedef enum logic [2:0] {
        S_IDLE,
        S_BUMP,
        S_DRAIN,
        S_THR,
        S_SCAN,
        S_FLUSH
    } t_state;

    // Accumulator memory command bundle
    typedef struct packed {
        logic   rd_en;
        t_idx   rd_addr;
        logic   wr_en;
        t_idx   wr_addr;
        t_count wr_data;
        logic   clear;
    } t_mem_cmd;

    localparam t_byte TRAN53 [ACC_N] = '{
        8'h02, 8'hD6, 8'h9E, 8'h6F, 8'hF9, 8'h1D, 8'h04, 8'hAB,
        8'hD0, 8'h22, 8'h16, 8'h1F, 8'hD8, 8'h73, 8'hA1, 8'hAC,
        8'h3B, 8'h70, 8'h62, 8'h96, 8'h1E, 8'h6E, 8'h8F, 8'h39,
        8'h9D, 8'h05, 8'h14, 8'h4A, 8'hA6, 8'hBE, 8'hAE, 8'h0E,
        8'hCF, 8'hB9, 8'h9C, 8'h9A, 8'hC7, 8'h68, 8'h13, 8'hE1,
        8'h2D, 8'hA4, 8'hEB, 8'h51, 8'h8D, 8'h64, 8'h6B, 8'h50,
        8'h23, 8'h80, 8'h03, 8'h41, 8'hEC, 8'hBB, 8'h71, 8'hCC,
        8'h7A, 8'h86, 8'h7F, 8'h98, 8'hF2, 8'h36, 8'h5E, 8'hEE,
        8'h8E, 8'hCE, 8'h4F, 8'hB8, 8'h32, 8'hB6, 8'h5F, 8'h59,
        8'hDC, 8'h1B, 8'h31, 8'h4C, 8'h7B, 8'hF0, 8'h63, 8'h01,
        8'h6C, 8'hBA, 8'h07, 8'hE8, 8'h12, 8'h77, 8'h49, 8'h3C,
        8'hDA, 8'h46, 8'hFE, 8'h2F, 8'h79, 8'h1C, 8'h9B, 8'h30,
        8'hE3, 8'h00, 8'h06, 8'h7E, 8'h2E, 8'h0F, 8'h38, 8'h33,
        8'h21, 8'hAD, 8'hA5, 8'h54, 8'hCA, 8'hA7, 8'h29, 8'hFC,
        8'h5A, 8'h47, 8'h69, 8'h7D, 8'hC5, 8'h95, 8'hB5, 8'hF4,
        8'h0B, 8'h90, 8'hA3, 8'h81, 8'h6D, 8'h25, 8'h55, 8'h35,
        8'hF5, 8'h75, 8'h74, 8'h0A, 8'h26, 8'hBF, 8'h19, 8'h5C,
        8'h1A, 8'hC6, 8'hFF, 8'h99, 8'h5D, 8'h84, 8'hAA, 8'h66,
        8'h3E, 8'hAF, 8'h78, 8'hB3, 8'h20, 8'h43, 8'hC1, 8'hED,
        8'h24, 8'hEA, 8'hE6, 8'h3F, 8'h18, 8'hF3, 8'hA0, 8'h42,
        8'h57, 8'h08, 8'h53, 8'h60, 8'hC3, 8'hC0, 8'h83, 8'h40,
        8'h82, 8'hD7, 8'h09, 8'hBD, 8'h44, 8'h2A, 8'h67, 8'hA8,
        8'h93, 8'hE0, 8'hC2, 8'h56, 8'h9F, 8'hD9, 8'hDD, 8'h85,
        8'h15, 8'hB4, 8'h8A, 8'h27, 8'h28, 8'h92, 8'h76, 8'hDE,
        8'hEF, 8'hF8, 8'hB2, 8'hB7, 8'hC9, 8'h3D, 8'h45, 8'h94,
        8'h4B, 8'h11, 8'h0D, 8'h65, 8'hD5, 8'h34, 8'h8B, 8'h91,
        8'h0C, 8'hFA, 8'h87, 8'hE9, 8'h7C, 8'h5B, 8'hB1, 8'h4D,
        8'hE5, 8'hD4, 8'hCB, 8'h10, 8'hA2, 8'h17, 8'h89, 8'hBC,
        8'hDB, 8'hB0, 8'hE2, 8'h97, 8'h88, 8'h52, 8'hF7, 8'h48,
        8'hD3, 8'h61, 8'h2C, 8'h3A, 8'h2B, 8'hD1, 8'h8C, 8'hFB,
        8'hF1, 8'hCD, 8'hE4, 8'h6A, 8'hE7, 8'hA9, 8'hFD, 8'hC4,
        8'h37, 8'hC8, 8'hD2, 8'hF6, 8'hDF, 8'h58, 8'h72, 8'h4E
    };

    function automatic t_byte tran53(input t_byte a);
        return TRAN53[a];
    endfunction

endpackage

// ----- hdl/nilsimsa_digest.sv -----
// Top level: Nilsimsa trigram digest engine with byte-command input and digest strobe output.
//
// Bytes are taken one per transaction (start high while busy is low). Each byte
// bumps 0, 1, 3 or 8 trigram accumulators (by how many history bytes are valid),
// one read-modify-write per cycle through the single port pair of the 256-entry
// counter memory, with busy held high until the bumps and the drain step are done. On
// a byte flagged last, the engine computes the threshold and scans all accumulators;
// the 32 digest bytes appear, highest index first, each for a single cycle with
// o_digest_valid high. The output cannot be stalled: the receiver must take each
// byte as it appears. After the digest all state is cleared at once, with no
// clearing pass.
module nilsimsa_digest #(
    parameter int LENGTH_BITS = 24
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_last_byte,
    output logic                 busy,
    output logic                 o_digest_valid,
    output logic [7:0]           o_digest_byte,
    output logic                 o_digest_last
);

    localparam int TOT_W = LENGTH_BITS + 3;
    localparam int THR_W = TOT_W - 8;

    nsd_pkg::t_state           r_state, n_state;
    nsd_pkg::t_byte            r_ch;
    logic                      r_last;
    nsd_pkg::t_byte            r_hist [nsd_pkg::HIST_N];
    logic [2:0]                r_hcnt;
    logic [LENGTH_BITS-1:0]    r_len;
    logic [2:0]                r_step;
    logic                      r_p_vld;
    nsd_pkg::t_idx             r_p_idx;
    logic                      r_w_vld;
    nsd_pkg::t_idx             r_w_idx;
    nsd_pkg::t_count           r_w_val;
    logic [THR_W-1:0]          r_thr;
    logic [4:0]                r_scan_byte;
    logic [2:0]                r_scan_bit;
    logic                      r_s_vld;
    logic [4:0]                r_s_byte;
    logic [2:0]                r_s_bit;
    nsd_pkg::t_byte            r_acc_byte;
    logic                      r_out_vld;
    nsd_pkg::t_byte            r_out_byte;
    logic                      r_out_last;

    logic                      accept;
    logic                      issue_bump;
    logic                      issue_scan;
    logic                      do_drain;
    logic                      do_thr;
    logic                      do_flush;
    logic [2:0]                last_step;
    nsd_pkg::t_idx             tri_idx;
    nsd_pkg::t_count           mem_rd;
    nsd_pkg::t_count           rd_val;
    nsd_pkg::t_count           inc_val;
    nsd_pkg::t_mem_cmd         mem_cmd;
    logic                      hit;
    nsd_pkg::t_byte            n_acc_byte;
    logic [TOT_W-1:0]          total;

    nsd_tri u_tri (
        .i_k   (r_step),
        .i_ch  (r_ch),
        .i_w0  (r_hist[0]),
        .i_w1  (r_hist[1]),
        .i_w2  (r_hist[2]),
        .i_w3  (r_hist[3]),
        .o_idx (tri_idx)
    );

    nsd_acc_mem u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (mem_cmd),
        .o_rd_data (mem_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= nsd_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        accept     = 1'b0;
        issue_bump = 1'b0;
        issue_scan = 1'b0;
        do_drain   = 1'b0;
        do_thr     = 1'b0;
        do_flush   = 1'b0;
        case (r_hcnt)
            3'd2:    last_step = 3'd0;
            3'd3:    last_step = 3'd2;
            default: last_step = 3'd7;
        endcase
        case (r_state)
            nsd_pkg::S_IDLE: begin
                if (start) begin
                    accept  = 1'b1;
                    n_state = (r_hcnt >= 3'd2) ? nsd_pkg::S_BUMP : nsd_pkg::S_DRAIN;
                end
            end
            nsd_pkg::S_BUMP: begin
                issue_bump = 1'b1;
                if (r_step == last_step) begin
                    n_state = nsd_pkg::S_DRAIN;
                end
            end
            nsd_pkg::S_DRAIN: begin
                do_drain = 1'b1;
                n_state  = r_last ? nsd_pkg::S_THR : nsd_pkg::S_IDLE;
            end
            nsd_pkg::S_THR: begin
                do_thr  = 1'b1;
                n_state = nsd_pkg::S_SCAN;
            end
            nsd_pkg::S_SCAN: begin
                issue_scan = 1'b1;
                if (r_scan_byte == 5'd0 && r_scan_bit == 3'd7) begin
                    n_state = nsd_pkg::S_FLUSH;
                end
            end
            nsd_pkg::S_FLUSH: begin
                do_flush = 1'b1;
                n_state  = nsd_pkg::S_IDLE;
            end
            default: begin
                n_state = nsd_pkg::S_IDLE;
            end
        endcase
    end

    // forward the write made in the cycle the read was issued
    always_comb begin
        rd_val  = (r_w_vld && r_w_idx == r_p_idx) ? r_w_val : mem_rd;
        inc_val = (rd_val == '1) ? rd_val : nsd_pkg::t_count'(rd_val + nsd_pkg::t_count'(1));
        hit     = mem_rd > nsd_pkg::t_count'(r_thr);
        n_acc_byte = r_acc_byte | (nsd_pkg::t_byte'(hit) << r_s_bit);
        total   = {r_len, 3'b000} - TOT_W'(nsd_pkg::TOTAL_OFFSET);

        mem_cmd.rd_en   = issue_bump | issue_scan;
        mem_cmd.rd_addr = issue_bump ? tri_idx : {r_scan_byte, r_scan_bit};
        mem_cmd.wr_en   = r_p_vld;
        mem_cmd.wr_addr = r_p_idx;
        mem_cmd.wr_data = inc_val;
        mem_cmd.clear   = do_flush;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist     <= '{default: '0};
            r_hcnt     <= '0;
            r_len      <= '0;
            r_p_vld    <= 1'b0;
            r_w_vld    <= 1'b0;
            r_s_vld    <= 1'b0;
            r_out_vld  <= 1'b0;
            r_acc_byte <= '0;
        end else begin
            r_p_vld   <= issue_bump;
            r_w_vld   <= r_p_vld;
            r_s_vld   <= issue_scan;
            r_out_vld <= r_s_vld && r_s_bit == 3'd7;

            if (do_drain) begin
                r_hist[3] <= r_hist[2];
                r_hist[2] <= r_hist[1];
                r_hist[1] <= r_hist[0];
                r_hist[0] <= r_ch;
                if (r_hcnt < 3'(nsd_pkg::HIST_N)) begin
                    r_hcnt <= r_hcnt + 3'd1;
                end
                if (r_len != '1) begin
                    r_len <= r_len + LENGTH_BITS'(1);
                end
            end

            if (do_thr) begin
                r_acc_byte <= '0;
            end else if (r_s_vld) begin
                r_acc_byte <= (r_s_bit == 3'd7) ? '0 : n_acc_byte;
            end

            if (do_flush) begin
                r_hist <= '{default: '0};
                r_hcnt <= '0;
                r_len  <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ch   <= i_data_byte;
            r_last <= i_last_byte;
            r_step <= '0;
        end else if (issue_bump) begin
            r_step <= r_step + 3'd1;
        end
        r_p_idx <= tri_idx;
        r_w_idx <= r_p_idx;
        r_w_val <= inc_val;
        if (do_thr) begin
            r_thr       <= (r_len > LENGTH_BITS'(nsd_pkg::SHORT_LEN)) ? total[TOT_W-1:8] : '0;
            r_scan_byte <= 5'd31;
            r_scan_bit  <= 3'd0;
        end else if (issue_scan) begin
            r_scan_bit <= r_scan_bit + 3'd1;
            if (r_scan_bit == 3'd7) begin
                r_scan_byte <= r_scan_byte - 5'd1;
            end
        end
        r_s_byte <= r_scan_byte;
        r_s_bit  <= r_scan_bit;
        if (r_s_vld && r_s_bit == 3'd7) begin
            r_out_byte <= n_acc_byte;
            r_out_last <= (r_s_byte == 5'd0);
        end
    end

    assign busy           = (r_state != nsd_pkg::S_IDLE);
    assign o_digest_valid = r_out_vld;
    assign o_digest_byte  = r_out_byte;
    // last flag only shows during the strobe cycle
    assign o_digest_last  = r_out_vld & r_out_last;

endmodule

// ----- hdl/nsd_tri.sv -----
// Trigram index unit: maps step number and window bytes to an accumulator index.
module nsd_tri (
    input  logic [2:0]     i_k,
    input  nsd_pkg::t_byte i_ch,
    input  nsd_pkg::t_byte i_w0,
    input  nsd_pkg::t_byte i_w1,
    input  nsd_pkg::t_byte i_w2,
    input  nsd_pkg::t_byte i_w3,
    output nsd_pkg::t_idx  o_idx
);

    nsd_pkg::t_byte x;
    nsd_pkg::t_byte y;
    nsd_pkg::t_byte z;
    nsd_pkg::t_byte kb;
    nsd_pkg::t_byte left;
    nsd_pkg::t_byte right;
    logic [3:0]     mul_k;
    logic [11:0]    prod;

    always_comb begin
        case (i_k)
            3'd0: begin x = i_ch; y = i_w0; z = i_w1; end
            3'd1: begin x = i_ch; y = i_w0; z = i_w2; end
            3'd2: begin x = i_ch; y = i_w1; z = i_w2; end
            3'd3: begin x = i_ch; y = i_w0; z = i_w3; end
            3'd4: begin x = i_ch; y = i_w1; z = i_w3; end
            3'd5: begin x = i_ch; y = i_w2; z = i_w3; end
            3'd6: begin x = i_w3; y = i_w0; z = i_ch; end
            default: begin x = i_w3; y = i_w2; z = i_ch; end
        endcase
        kb    = nsd_pkg::t_byte'(i_k);
        mul_k = {i_k, 1'b1};    // 2k+1
        prod  = 12'(nsd_pkg::tran53(y)) * 12'(mul_k);
        left  = nsd_pkg::tran53(nsd_pkg::t_byte'(x + kb)) ^ prod[7:0];
        right = nsd_pkg::tran53(z ^ nsd_pkg::tran53(kb));
        o_idx = nsd_pkg::t_idx'(left + right);
    end

endmodule

// ----- hdl/nsd_acc_mem.sv -----
// Trigram accumulator memory with per-entry valid bits for instant clear.
module nsd_acc_mem (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  nsd_pkg::t_mem_cmd i_cmd,
    output nsd_pkg::t_count   o_rd_data
);

    nsd_pkg::t_count            r_mem [nsd_pkg::ACC_N];
    logic [nsd_pkg::ACC_N-1:0]  r_valid;
    nsd_pkg::t_count            r_rd_data;
    logic                       r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[i_cmd.wr_addr] <= i_cmd.wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[i_cmd.rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_cmd.wr_en) begin
                r_valid[i_cmd.wr_addr] <= 1'b1;
            end
            if (i_cmd.rd_en) begin
                r_rd_vld <= r_valid[i_cmd.rd_addr];
            end
        end
    end

    // unwritten entries read as zero
    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

// ----- hdl/nsd_checker.sv -----
// Port-level checker for the digest engine, bound to the top level.
module nsd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       o_digest_valid,
    input logic [7:0] o_digest_byte,
    input logic       o_digest_last
);

    // an accepted byte always makes the engine busy in the cycle after
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("engine not busy after accepting a transaction");

    a_last_marks_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_digest_last |-> o_digest_valid)
        else $error("digest_last without strobe");

    // digest bytes are spaced by the scan of their accumulators, never back to back
    a_strobe_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_digest_valid |=> !o_digest_valid)
        else $error("digest strobes back to back");

    a_more_bytes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_digest_valid && !o_digest_last) |=> busy)
        else $error("engine idle before digest completed");

    a_byte_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_digest_valid |-> !$isunknown(o_digest_byte))
        else $error("digest byte unknown during strobe");

endmodule

bind nilsimsa_digest nsd_checker u_nsd_checker (.*);
